@@ rtl/tcrc_pkg.sv @@
// Package for the three-channel root counter timer: types, codes and interrupt helper.
`timescale 1ns / 1ps
package tcrc_pkg;

  // Default number of timers and fixed field widths
  localparam int TCRC_TIMER_COUNT = 3;
  localparam int TCRC_CNT_W       = 16;
  localparam int TCRC_CTL_W       = 13;
  localparam int TCRC_AMT_W       = 12;
  localparam int TCRC_IRQ_W       = 3;
  localparam int TCRC_NEXT_W      = TCRC_CNT_W + 1;

  localparam logic [TCRC_CNT_W-1:0]  TCRC_LIMIT_MAX = 16'hFFFF;
  localparam logic [TCRC_NEXT_W-1:0] TCRC_LIMIT_EXT = 17'h0FFFF;

  // Control word bit positions
  localparam int CTL_WRAP_TGT  = 3;
  localparam int CTL_IRQ_TGT   = 4;
  localparam int CTL_IRQ_MAX   = 5;
  localparam int CTL_REPEAT    = 6;
  localparam int CTL_TOGGLE    = 7;
  localparam int CTL_IRQ_LINE  = 10;
  localparam int CTL_HIT_TGT   = 11;
  localparam int CTL_HIT_MAX   = 12;
  localparam int CTL_WR_W      = 10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_COUNT   = 2'd0,
    REG_CONTROL = 2'd1,
    REG_TARGET  = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TGT,
    S_DIV,
    S_TFIRE,
    S_LIM,
    S_FIN
  } state_t;

  // Request to and response from the shared remainder unit
  typedef struct packed {
    logic                   start;
    logic [TCRC_NEXT_W-1:0] dividend;
    logic [TCRC_CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [TCRC_CNT_W-1:0] remainder;
  } div_resp_t;

  typedef struct packed {
    logic [TCRC_CTL_W-1:0] ctl;
    logic                  armed;
    logic                  raised;
  } irq_res_t;

  // Interrupt logic: pulse or toggle the active-low line, detect its falling edge
  function automatic irq_res_t fire_irq(input logic [TCRC_CTL_W-1:0] ctl,
                                        input logic armed);
    irq_res_t r;
    logic     line_prev;
    logic     line_post;
    line_prev = ctl[CTL_IRQ_LINE];
    line_post = ctl[CTL_TOGGLE] ? ~line_prev : 1'b0;
    r.raised = armed & line_prev & ~line_post;
    r.ctl    = ctl;
    r.ctl[CTL_IRQ_LINE] = ctl[CTL_TOGGLE] ? line_post : 1'b1;
    r.armed  = ctl[CTL_REPEAT] ? armed : 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/tcrc_in_if.sv @@
// Request channel interface: valid/ready handshake with the request fields.
`timescale 1ns / 1ps
interface tcrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  timer_select;
  logic [1:0]  register_select;
  logic [15:0] write_data;
  logic [11:0] tick_amount;

  modport source (output valid, operation, timer_select, register_select, write_data,
                  tick_amount, input ready);
  modport sink (input valid, operation, timer_select, register_select, write_data,
                tick_amount, output ready);
endinterface

@@ rtl/tcrc_out_if.sv @@
// Result channel interface: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
interface tcrc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [2:0]  irq_raised;

  modport source (output valid, read_data, irq_raised, input ready);
  modport sink (input valid, read_data, irq_raised, output ready);
endinterface

@@ rtl/tcrc_mod_unit.sv @@
// Bit-serial restoring remainder unit shared by all timers for the target wrap.
`timescale 1ns / 1ps
module tcrc_mod_unit
  import tcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  localparam int STEP_W = $clog2(TCRC_NEXT_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TCRC_NEXT_W - 1);

  logic                   busy;
  logic                   done;
  logic [STEP_W-1:0]      step;
  logic [TCRC_CNT_W-1:0]  rem;
  logic [TCRC_NEXT_W-1:0] dvd;
  logic [TCRC_CNT_W-1:0]  dsr;
  logic [TCRC_NEXT_W-1:0] trial;
  logic [TCRC_NEXT_W-1:0] diff;

  // Shift in the next dividend bit and try one subtract
  assign trial = {rem, dvd[TCRC_NEXT_W-1]};
  assign diff  = trial - {1'b0, dsr};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Partial remainder and operands
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[TCRC_NEXT_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff[TCRC_CNT_W-1:0];
      end else begin
        rem <= trial[TCRC_CNT_W-1:0];
      end
    end
  end

  assign resp.done      = done;
  assign resp.remainder = rem;

endmodule

@@ rtl/three_channel_root_counter_timer.sv @@
// Top level: three root counter timers with a sequencer and a shared remainder unit.
//
//   channel  | dir | fields                                                  | handshake
//   in_ch    | in  | operation, timer_select, register_select, write_data,  | valid/ready
//            |     | tick_amount                                             |
//   out_ch   | out | read_data, irq_raised                                   | valid/ready
//
// A read, write or idle operation goes from accept through dispatch to the final state.
// A tick visits the timers one after another: a timer that crosses nothing passes
// the target and limit states, a target crossing adds the target-fire state, and a
// wrap at the target also waits in the divide state while the bit-serial remainder
// unit takes 17 steps, one per dividend bit, and then flags done.
// Reset (rst, synchronous) clears all counters, targets, control words and flags.
// The result sits in an output register; a new request is taken while it waits,
// and the sequencer stalls at its last step only if the previous result is untaken.
`timescale 1ns / 1ps
module three_channel_root_counter_timer
  import tcrc_pkg::*;
#(
  parameter int TIMER_COUNT = TCRC_TIMER_COUNT
) (
  input logic       clk,
  input logic       rst,
  tcrc_in_if.sink   in_ch,
  tcrc_out_if.source out_ch
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  state_t state, state_next;

  // Timer state
  logic [TCRC_CNT_W-1:0] count_value     [TIMER_COUNT];
  logic [TCRC_CNT_W-1:0] target_value    [TIMER_COUNT];
  logic [TCRC_CTL_W-1:0] control_word    [TIMER_COUNT];
  logic                  interrupt_armed [TIMER_COUNT];

  // Latched request
  op_t                   op;
  logic [1:0]            tsel;
  reg_sel_t              rsel;
  logic [TCRC_CNT_W-1:0] wdata;
  logic [TCRC_AMT_W-1:0] amount;

  logic [IDX_W-1:0]       idx;
  logic [TCRC_NEXT_W-1:0] nxt;
  logic [TCRC_CNT_W-1:0]  rd;
  logic [TCRC_IRQ_W-1:0]  irq_acc;

  logic                  out_valid;
  logic [TCRC_CNT_W-1:0] out_rd;
  logic [TCRC_IRQ_W-1:0] out_irq;

  div_req_t  div_req;
  div_resp_t div_resp;

  logic                   in_fire;
  logic                   out_free;
  logic                   tsel_ok;
  logic [IDX_W-1:0]       sel;
  logic [TCRC_CNT_W-1:0]  cur_cnt;
  logic [TCRC_CNT_W-1:0]  cur_tgt;
  logic [TCRC_CTL_W-1:0]  cur_ctl;
  logic                   cur_arm;
  logic [TCRC_NEXT_W-1:0] sum;
  logic                   tgt_cross;
  logic                   lim_cross;
  irq_res_t               irq_t;
  irq_res_t               irq_l;

  tcrc_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Select the timer: request address while dispatching, sweep index otherwise
  assign tsel_ok = (int'(tsel) < TIMER_COUNT);
  assign sel     = (state == S_DISPATCH) ? tsel[IDX_W-1:0] : idx;
  assign cur_cnt = count_value[sel];
  assign cur_tgt = target_value[sel];
  assign cur_ctl = control_word[sel];
  assign cur_arm = interrupt_armed[sel];

  // Crossing tests against target and the 16-bit limit
  assign sum       = {1'b0, cur_cnt} + {{(TCRC_NEXT_W-TCRC_AMT_W){1'b0}}, amount};
  assign tgt_cross = (cur_cnt < cur_tgt) && (sum >= {1'b0, cur_tgt});
  assign lim_cross = (cur_cnt < TCRC_LIMIT_MAX) && (nxt >= TCRC_LIMIT_EXT);
  assign irq_t     = fire_irq(cur_ctl, cur_arm);
  assign irq_l     = fire_irq(cur_ctl, cur_arm);

  assign div_req.start    = (state == S_TGT) && tgt_cross && cur_ctl[CTL_WRAP_TGT];
  assign div_req.dividend = sum;
  assign div_req.divisor  = cur_tgt;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = (op == OP_TICK) ? S_TGT : S_FIN;
      end
      S_TGT: begin
        if (!tgt_cross) begin
          state_next = S_LIM;
        end else if (cur_ctl[CTL_WRAP_TGT]) begin
          state_next = S_DIV;
        end else begin
          state_next = S_TFIRE;
        end
      end
      S_DIV: begin
        if (div_resp.done) state_next = S_TFIRE;
      end
      S_TFIRE: begin
        state_next = S_LIM;
      end
      S_LIM: begin
        state_next = (idx == LAST_IDX) ? S_FIN : S_TGT;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op     <= op_t'(in_ch.operation);
      tsel   <= in_ch.timer_select;
      rsel   <= reg_sel_t'(in_ch.register_select);
      wdata  <= in_ch.write_data;
      amount <= in_ch.tick_amount;
    end
  end

  // Timer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        count_value[i]     <= '0;
        target_value[i]    <= '0;
        control_word[i]    <= '0;
        interrupt_armed[i] <= 1'b0;
      end
      idx     <= '0;
      irq_acc <= '0;
      rd      <= '0;
      nxt     <= '0;
    end else begin
      case (state)
        S_DISPATCH: begin
          idx     <= '0;
          irq_acc <= '0;
          if (op == OP_READ && tsel_ok) begin
            case (rsel)
              REG_COUNT:   rd <= cur_cnt;
              REG_CONTROL: rd <= {{(TCRC_CNT_W-TCRC_CTL_W){1'b0}}, cur_ctl};
              REG_TARGET:  rd <= cur_tgt;
              default:     rd <= '0;
            endcase
          end else begin
            rd <= '0;
          end
          if (op == OP_WRITE && tsel_ok) begin
            case (rsel)
              REG_COUNT: count_value[sel] <= wdata;
              REG_CONTROL: begin
                control_word[sel] <= {cur_ctl[CTL_HIT_MAX:CTL_HIT_TGT], 1'b1,
                                      wdata[CTL_WR_W-1:0]};
                interrupt_armed[sel] <= 1'b1;
              end
              REG_TARGET: target_value[sel] <= wdata;
              default: ;
            endcase
          end
        end
        S_TGT: begin
          nxt <= sum;
        end
        S_DIV: begin
          if (div_resp.done) nxt <= {1'b0, div_resp.remainder};
        end
        // Target reached: optional interrupt, set the target status bit
        S_TFIRE: begin
          if (cur_ctl[CTL_IRQ_TGT]) begin
            control_word[sel]    <= irq_t.ctl | TCRC_CTL_W'(1 << CTL_HIT_TGT);
            interrupt_armed[sel] <= irq_t.armed;
            irq_acc[idx]         <= irq_acc[idx] | irq_t.raised;
          end else begin
            control_word[sel] <= cur_ctl | TCRC_CTL_W'(1 << CTL_HIT_TGT);
          end
        end
        // Limit reached: wrap unless wrapping at target, optional interrupt, set status; store the counter
        S_LIM: begin
          if (lim_cross) begin
            if (cur_ctl[CTL_IRQ_MAX]) begin
              control_word[sel]    <= irq_l.ctl | TCRC_CTL_W'(1 << CTL_HIT_MAX);
              interrupt_armed[sel] <= irq_l.armed;
              irq_acc[idx]         <= irq_acc[idx] | irq_l.raised;
            end else begin
              control_word[sel] <= cur_ctl | TCRC_CTL_W'(1 << CTL_HIT_MAX);
            end
            if (!cur_ctl[CTL_WRAP_TGT]) begin
              count_value[sel] <= nxt[TCRC_CNT_W-1:0] - TCRC_LIMIT_MAX;
            end else begin
              count_value[sel] <= nxt[TCRC_CNT_W-1:0];
            end
          end else begin
            count_value[sel] <= nxt[TCRC_CNT_W-1:0];
          end
          if (idx != LAST_IDX) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: load the finished result, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_rd  <= (op == OP_READ) ? rd : '0;
      out_irq <= (op == OP_TICK) ? irq_acc : '0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_data  = out_rd;
  assign out_ch.irq_raised = out_irq;

endmodule
